// ===== hdl/vsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsp_pkg
// Shared types, constants and character helpers for the version text parser.
// ----------------------------------------------------------------------------
package vsp_pkg;

    localparam int VALUE_W   = 30;
    localparam int CHAR_W    = 8;
    localparam int PRE_LEN_W = 6;
    localparam int TAIL_W    = 7;
    localparam int PARTS     = 3;

    localparam logic [TAIL_W-1:0]    TAIL_SAT      = 7'd64;
    localparam logic [PRE_LEN_W-1:0] PRE_LEN_RESET = 6'd32;
    localparam logic [1:0]           COMP_FULL     = 2'd3;

    localparam logic [CHAR_W-1:0] CH_DOT  = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_DASH = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_0    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9    = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UZ   = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LA   = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LZ   = 8'h7A;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_MISSING   = 3'd1,
        ST_OVERSIZED = 3'd2,
        ST_RANGE     = 3'd3,
        ST_ENCODING  = 3'd4,
        ST_MALFORMED = 3'd5
    } t_status;

    typedef struct packed {
        logic               in_prerelease;
        logic               text_done;
        t_status            status;
        logic [VALUE_W-1:0] major_value;
        logic [VALUE_W-1:0] minor_value;
        logic [VALUE_W-1:0] patch_value;
    } t_result;

    function automatic logic is_dec_char(input logic [CHAR_W-1:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
        return is_dec_char(c) || ((c >= CH_UA) && (c <= CH_UZ)) ||
               ((c >= CH_LA) && (c <= CH_LZ));
    endfunction

endpackage

// ===== hdl/vsp_intf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsp_intf
// Valid/ready channels: character input, parse result output, config write.
// ----------------------------------------------------------------------------
interface vsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;
    logic       empty_text;

    modport source (output valid, char_code, last_char, empty_text, input ready);
    modport sink   (input valid, char_code, last_char, empty_text, output ready);
endinterface

interface vsp_out_if;
    logic        valid;
    logic        ready;
    logic        in_prerelease;
    logic        text_done;
    logic [2:0]  status;
    logic [29:0] major_value;
    logic [29:0] minor_value;
    logic [29:0] patch_value;

    modport source (output valid, in_prerelease, text_done, status, major_value,
                    minor_value, patch_value, input ready);
    modport sink   (input valid, in_prerelease, text_done, status, major_value,
                    minor_value, patch_value, output ready);
endinterface

interface vsp_cfg_if;
    logic       valid;
    logic       ready;
    logic [5:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/vsp_parse_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsp_parse_core
// Running parse state, one character per accepted beat, result per beat.
// ----------------------------------------------------------------------------
module vsp_parse_core #(
    parameter int MAX_TEXT_LEN         = 64,
    parameter int MAX_COMPONENT_DIGITS = 9
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  logic [vsp_pkg::CHAR_W-1:0]        i_char_code,
    input  logic                              i_last_char,
    input  logic                              i_empty_text,
    input  logic [vsp_pkg::PRE_LEN_W-1:0]     i_max_pre_len,
    output vsp_pkg::t_result                  o_result
);
    import vsp_pkg::*;

    localparam int CNT_W = $clog2(MAX_TEXT_LEN + 2);
    localparam int LEN_W = $clog2(MAX_COMPONENT_DIGITS + 2);

    logic [CNT_W-1:0]   r_char_count, n_char_count;
    logic               r_seen_dash, n_seen_dash;
    logic [TAIL_W-1:0]  r_tail_len, n_tail_len;
    logic               r_tail_bad, n_tail_bad;
    t_status            r_body_err, n_body_err;
    logic [1:0]         r_comp_count, n_comp_count;
    logic [LEN_W-1:0]   r_comp_len, n_comp_len;
    logic               r_comp_nondig, n_comp_nondig;
    logic [VALUE_W-1:0] r_run_val, n_run_val;
    logic [VALUE_W-1:0] r_parts [PARTS];
    logic [VALUE_W-1:0] n_parts [PARTS];

    logic               w_close;
    logic               w_in_tail;
    logic [VALUE_W+3:0] w_mul;
    t_status            w_status;

    assign w_mul = {1'b0, r_run_val, 3'b000} + {3'b000, r_run_val, 1'b0} +
                   (VALUE_W + 4)'(i_char_code[3:0]);

    always_comb begin
        n_char_count  = r_char_count;
        n_seen_dash   = r_seen_dash;
        n_tail_len    = r_tail_len;
        n_tail_bad    = r_tail_bad;
        n_body_err    = r_body_err;
        n_comp_count  = r_comp_count;
        n_comp_len    = r_comp_len;
        n_comp_nondig = r_comp_nondig;
        n_run_val     = r_run_val;
        n_parts       = r_parts;
        w_close       = 1'b0;
        w_in_tail     = 1'b0;
        w_status      = ST_OK;
        o_result      = '0;

        if (!i_empty_text) begin
            if (r_char_count <= CNT_W'(MAX_TEXT_LEN)) begin
                n_char_count = r_char_count + 1'b1;
            end
            if (r_seen_dash) begin
                w_in_tail = 1'b1;
                if (r_tail_len < TAIL_SAT) begin
                    n_tail_len = r_tail_len + 1'b1;
                end
                if (!is_alnum(i_char_code) && (i_char_code != CH_DOT)) begin
                    n_tail_bad = 1'b1;
                end
            end else if (i_char_code == CH_DASH) begin
                w_close     = (r_comp_len != '0);
                n_seen_dash = 1'b1;
            end else if (i_char_code == CH_DOT) begin
                w_close = 1'b1;
            end else begin
                if (!is_dec_char(i_char_code)) begin
                    n_comp_nondig = 1'b1;
                end else if (r_comp_len < LEN_W'(MAX_COMPONENT_DIGITS)) begin
                    n_run_val = w_mul[VALUE_W-1:0];
                end
                if (r_comp_len <= LEN_W'(MAX_COMPONENT_DIGITS)) begin
                    n_comp_len = r_comp_len + 1'b1;
                end
            end
        end

        // end of body closes a pending component
        if (i_last_char && !n_seen_dash && (n_comp_len != '0)) begin
            w_close = 1'b1;
        end

        if (w_close) begin
            if (r_body_err == ST_OK) begin
                if (r_comp_count == COMP_FULL) begin
                    n_body_err = ST_RANGE;
                end else if ((n_comp_len == '0) ||
                             (n_comp_len > LEN_W'(MAX_COMPONENT_DIGITS))) begin
                    n_body_err = ST_RANGE;
                end else if (n_comp_nondig) begin
                    n_body_err = ST_ENCODING;
                end else begin
                    for (int k = 0; k < PARTS; k++) begin
                        if (r_comp_count == 2'(k)) begin
                            n_parts[k] = n_run_val;
                        end
                    end
                    n_comp_count = r_comp_count + 1'b1;
                end
            end
            n_comp_len    = '0;
            n_comp_nondig = 1'b0;
            n_run_val     = '0;
        end

        o_result.in_prerelease = w_in_tail;

        if (i_last_char) begin
            priority if (n_char_count == '0) begin
                w_status = ST_MISSING;
            end else if (n_char_count > CNT_W'(MAX_TEXT_LEN)) begin
                w_status = ST_OVERSIZED;
            end else if (n_seen_dash && (n_tail_len == '0)) begin
                w_status = ST_RANGE;
            end else if (n_seen_dash && (n_tail_len > {1'b0, i_max_pre_len})) begin
                w_status = ST_OVERSIZED;
            end else if (n_seen_dash && n_tail_bad) begin
                w_status = ST_ENCODING;
            end else if (n_body_err != ST_OK) begin
                w_status = n_body_err;
            end else if (n_comp_count != COMP_FULL) begin
                w_status = ST_MALFORMED;
            end else begin
                w_status = ST_OK;
            end

            o_result.text_done = 1'b1;
            o_result.status    = w_status;
            if (w_status == ST_OK) begin
                o_result.major_value = n_parts[0];
                o_result.minor_value = n_parts[1];
                o_result.patch_value = n_parts[2];
            end

            // clear for the next text
            n_char_count  = '0;
            n_seen_dash   = 1'b0;
            n_tail_len    = '0;
            n_tail_bad    = 1'b0;
            n_body_err    = ST_OK;
            n_comp_count  = '0;
            n_comp_len    = '0;
            n_comp_nondig = 1'b0;
            n_run_val     = '0;
            for (int k = 0; k < PARTS; k++) begin
                n_parts[k] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_count  <= '0;
            r_seen_dash   <= 1'b0;
            r_tail_len    <= '0;
            r_tail_bad    <= 1'b0;
            r_body_err    <= ST_OK;
            r_comp_count  <= '0;
            r_comp_len    <= '0;
            r_comp_nondig <= 1'b0;
            r_run_val     <= '0;
            for (int k = 0; k < PARTS; k++) begin
                r_parts[k] <= '0;
            end
        end else if (i_accept) begin
            r_char_count  <= n_char_count;
            r_seen_dash   <= n_seen_dash;
            r_tail_len    <= n_tail_len;
            r_tail_bad    <= n_tail_bad;
            r_body_err    <= n_body_err;
            r_comp_count  <= n_comp_count;
            r_comp_len    <= n_comp_len;
            r_comp_nondig <= n_comp_nondig;
            r_run_val     <= n_run_val;
            r_parts       <= n_parts;
        end
    end

endmodule

// ===== hdl/vsp_out_skid.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsp_out_skid
// Result register with a skid entry so one more result is taken under a stall.
// ----------------------------------------------------------------------------
module vsp_out_skid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  vsp_pkg::t_result i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output vsp_pkg::t_result o_data
);
    import vsp_pkg::*;

    logic    r_main_valid, n_main_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_main, n_main;
    t_result r_skid, n_skid;
    logic    w_push;
    logic    w_pop;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;
    assign w_push  = i_valid && o_ready;
    assign w_pop   = r_main_valid && i_ready;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (w_pop) begin
            if (r_skid_valid) begin
                n_main       = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_main_valid = 1'b0;
            end
        end
        if (w_push) begin
            if (!n_main_valid) begin
                n_main       = i_data;
                n_main_valid = 1'b1;
            end else begin
                n_skid       = i_data;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_main <= n_main;
        r_skid <= n_skid;
    end

endmodule

// ===== hdl/version_string_parser_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// version_string_parser_top
// Streaming major.minor.patch[-prerelease] parser, one character per beat.
//
//   channel  dir  payload                                      beat
//   i_in     in   char_code, last_char, empty_text             valid & ready
//   o_out    out  in_prerelease, text_done, status, 3 values    valid & ready
//   i_cfg    in   data = max_prerelease_len                    valid & ready
//
// one beat per cycle while input ready is high; each input beat yields one result
// beat, held in the result register
// reset clears parse state and output valids; max_prerelease_len returns to 32
// a stalled output holds one result plus one in the skid entry; input ready
// drops only while the skid entry is full
// cfg is always ready
// ----------------------------------------------------------------------------
module version_string_parser_top #(
    parameter int MAX_TEXT_LEN         = 64,
    parameter int MAX_COMPONENT_DIGITS = 9
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vsp_cfg_if.sink   i_cfg,
    vsp_in_if.sink    i_in,
    vsp_out_if.source o_out
);
    import vsp_pkg::*;

    logic [PRE_LEN_W-1:0] r_max_pre_len;
    logic                 w_accept;
    logic                 w_ready;
    t_result              w_result;
    t_result              w_out;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_pre_len <= PRE_LEN_RESET;
        end else if (i_cfg.valid) begin
            r_max_pre_len <= i_cfg.data;
        end
    end

    assign i_in.ready = w_ready;
    assign w_accept   = i_in.valid && w_ready;

    vsp_parse_core #(
        .MAX_TEXT_LEN         (MAX_TEXT_LEN),
        .MAX_COMPONENT_DIGITS (MAX_COMPONENT_DIGITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_char_code   (i_in.char_code),
        .i_last_char   (i_in.last_char),
        .i_empty_text  (i_in.empty_text),
        .i_max_pre_len (r_max_pre_len),
        .o_result      (w_result)
    );

    vsp_out_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (w_ready),
        .i_data  (w_result),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_data  (w_out)
    );

    assign o_out.in_prerelease = w_out.in_prerelease;
    assign o_out.text_done     = w_out.text_done;
    assign o_out.status        = w_out.status;
    assign o_out.major_value   = w_out.major_value;
    assign o_out.minor_value   = w_out.minor_value;
    assign o_out.patch_value   = w_out.patch_value;

endmodule

// ===== test/version_string_parser_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// version_string_parser_top_tb
// Drives version texts into the parser one character per beat, with random
// gaps and back pressure. A directed table covers empty text, ignored beats,
// the trailing dot, extreme codes and every error status but oversized. Random texts follow
// (mostly well formed, some broken, some noise) under several tail limits.
// Every result beat is checked field by field against a table literal or a parse model.
// ----------------------------------------------------------------------------
module version_string_parser_top_tb;
    import vsp_pkg::*;

    localparam int TEXT_MAX     = 64;
    localparam int DIGITS_MAX   = 9;
    localparam int ITEMS_TOTAL  = 1300;
    localparam int PHASES       = 7;
    localparam int PHASE_ITEMS  = (ITEMS_TOTAL - 24) / PHASES;
    localparam int HOLD_CYCLES  = 100;
    localparam int ROWS         = 24;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last_char;
        logic              empty_text;
    } t_char_beat;

    typedef struct packed {
        t_char_beat beat;
        logic       has_lit;
        t_result    lit;
    } t_row;

    localparam t_result NO_LIT = '0;

    logic i_clk;
    logic i_rst_n;

    vsp_in_if  in_if ();
    vsp_out_if out_if ();
    vsp_cfg_if cfg_if ();

    version_string_parser_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // directed stimulus
    t_row directed_table [ROWS] = '{
        '{'{8'h00, 1'b1, 1'b1}, 1'b1, '{1'b0, 1'b1, ST_MISSING, 30'd0, 30'd0, 30'd0}},
        '{'{8'hFF, 1'b0, 1'b1}, 1'b1, NO_LIT},
        '{'{"1", 1'b0, 1'b0}, 1'b0, NO_LIT},
        '{'{CH_DOT, 1'b0, 1'b0}, 1'b0, NO_LIT},
        '{'{"2", 1'b0, 1'b0}, 1'b0, NO_LIT},
        '{'{CH_DOT, 1'b0, 1'b0}, 1'b0, NO_LIT},
        '{'{"3", 1'b0, 1'b0}, 1'b0, NO_LIT},
        '{'{CH_DASH, 1'b0, 1'b0}, 1'b0, NO_LIT},
        '{'{"a", 1'b1, 1'b0}, 1'b1, '{1'b1, 1'b1, ST_OK, 30'd1, 30'd2, 30'd3}},
        '{'{"1", 1'b0, 1'b0}, 1'b0, NO_LIT},
        '{'{CH_DOT, 1'b0, 1'b0}, 1'b0, NO_LIT},
        '{'{"2", 1'b0, 1'b0}, 1'b0, NO_LIT},
        '{'{CH_DASH, 1'b1, 1'b0}, 1'b1, '{1'b0, 1'b1, ST_RANGE, 30'd0, 30'd0, 30'd0}},
        '{'{"9", 1'b0, 1'b0}, 1'b0, NO_LIT},
        '{'{CH_DOT, 1'b0, 1'b0}, 1'b0, NO_LIT},
        '{'{"0", 1'b0, 1'b0}, 1'b0, NO_LIT},
        '{'{CH_DOT, 1'b0, 1'b0}, 1'b0, NO_LIT},
        '{'{"9", 1'b0, 1'b0}, 1'b0, NO_LIT},
        '{'{CH_DOT, 1'b1, 1'b0}, 1'b1, '{1'b0, 1'b1, ST_OK, 30'd9, 30'd0, 30'd9}},
        '{'{8'hFF, 1'b1, 1'b0}, 1'b1, '{1'b0, 1'b1, ST_ENCODING, 30'd0, 30'd0, 30'd0}},
        '{'{8'h00, 1'b1, 1'b0}, 1'b1, '{1'b0, 1'b1, ST_ENCODING, 30'd0, 30'd0, 30'd0}},
        '{'{"1", 1'b0, 1'b0}, 1'b0, NO_LIT},
        '{'{CH_DOT, 1'b0, 1'b0}, 1'b0, NO_LIT},
        '{'{"2", 1'b1, 1'b0}, 1'b1, '{1'b0, 1'b1, ST_MALFORMED, 30'd0, 30'd0, 30'd0}}
    };

    // parse model state
    logic [PRE_LEN_W-1:0] max_tail_len;
    logic [6:0]           text_len;
    logic                 dash_seen;
    logic [TAIL_W-1:0]    tail_len;
    logic                 tail_bad;
    t_status              body_status;
    logic [1:0]           piece_count;
    logic [3:0]           piece_len;
    logic                 piece_nondigit;
    logic [VALUE_W-1:0]   piece_value;
    logic [VALUE_W-1:0]   version_parts [PARTS];

    t_result    expected_results [$];
    t_char_beat text_q [$];
    int         error_count = 0;

    logic    beat_has_lit;
    t_result beat_lit;
    logic    hold_req;
    logic    no_idle;
    int      rx_burst;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic tail_char_legal(input logic [CHAR_W-1:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
               (c >= "a" && c <= "z") || (c == CH_DOT);
    endfunction

    task automatic clear_text_state();
        text_len       = '0;
        dash_seen      = 1'b0;
        tail_len       = '0;
        tail_bad       = 1'b0;
        body_status    = ST_OK;
        piece_count    = '0;
        piece_len      = '0;
        piece_nondigit = 1'b0;
        piece_value    = '0;
        for (int i = 0; i < PARTS; i++) version_parts[i] = '0;
    endtask

    task automatic close_piece();
        if (body_status == ST_OK) begin
            if (piece_count >= COMP_FULL)
                body_status = ST_RANGE;
            else if (piece_len == 0 || piece_len > DIGITS_MAX)
                body_status = ST_RANGE;
            else if (piece_nondigit)
                body_status = ST_ENCODING;
            else begin
                version_parts[piece_count] = piece_value;
                piece_count = piece_count + 2'd1;
            end
        end
        piece_len      = '0;
        piece_nondigit = 1'b0;
        piece_value    = '0;
    endtask

    task automatic parse_char(input t_char_beat b, output t_result r);
        logic [33:0]   wide;
        t_status       st;
        logic [CHAR_W-1:0] c;
        c = b.char_code;
        r = '0;
        if (!b.empty_text) begin
            if (text_len <= TEXT_MAX) text_len = text_len + 7'd1;
            if (dash_seen) begin
                r.in_prerelease = 1'b1;
                if (tail_len < TAIL_SAT) tail_len = tail_len + 7'd1;
                if (!tail_char_legal(c)) tail_bad = 1'b1;
            end else if (c == CH_DASH) begin
                if (piece_len > 0) close_piece();
                dash_seen = 1'b1;
            end else if (c == CH_DOT) begin
                close_piece();
            end else begin
                if (c < CH_0 || c > CH_9)
                    piece_nondigit = 1'b1;
                else if (piece_len < DIGITS_MAX) begin
                    wide = {4'd0, piece_value} * 34'd10 + {26'd0, c - CH_0};
                    piece_value = wide[VALUE_W-1:0];
                end
                if (piece_len <= DIGITS_MAX) piece_len = piece_len + 4'd1;
            end
        end
        if (b.last_char) begin
            if (!dash_seen && piece_len > 0) close_piece();
            if (text_len == 0)
                st = ST_MISSING;
            else if (text_len > TEXT_MAX)
                st = ST_OVERSIZED;
            else if (dash_seen && tail_len == 0)
                st = ST_RANGE;
            else if (dash_seen && tail_len > {1'b0, max_tail_len})
                st = ST_OVERSIZED;
            else if (dash_seen && tail_bad)
                st = ST_ENCODING;
            else if (body_status != ST_OK)
                st = body_status;
            else if (piece_count != COMP_FULL)
                st = ST_MALFORMED;
            else
                st = ST_OK;
            r.text_done = 1'b1;
            r.status    = st;
            if (st == ST_OK) begin
                r.major_value = version_parts[0];
                r.minor_value = version_parts[1];
                r.patch_value = version_parts[2];
            end
            clear_text_state();
        end
    endtask

    task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
                               input logic [VALUE_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) max_tail_len = cfg_if.data;
            if (in_if.valid && in_if.ready) begin
                parse_char('{in_if.char_code, in_if.last_char, in_if.empty_text}, want);
                if (beat_has_lit) want = beat_lit;
                expected_results.insert(expected_results.size(), want);
            end
            if (out_if.valid && out_if.ready) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with no expectation waiting");
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("in_prerelease", VALUE_W'(want.in_prerelease),
                                VALUE_W'(out_if.in_prerelease));
                    check_field("text_done", VALUE_W'(want.text_done),
                                VALUE_W'(out_if.text_done));
                    check_field("status", VALUE_W'(want.status), VALUE_W'(out_if.status));
                    check_field("major_value", want.major_value, out_if.major_value);
                    check_field("minor_value", want.minor_value, out_if.minor_value);
                    check_field("patch_value", want.patch_value, out_if.patch_value);
                end
            end
        end
    end

    // result side back pressure
    initial begin
        out_if.ready = 1'b0;
        rx_burst     = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
                out_if.ready <= 1'b1;
            end else if (rx_burst != 0) begin
                out_if.ready <= 1'b0;
                rx_burst--;
            end else if (!no_idle && $urandom_range(0, 9) == 0) begin
                rx_burst = $urandom_range(1, 19) - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    task automatic send_beat(input t_char_beat b, input logic has_lit, input t_result lit);
        @(negedge i_clk);
        beat_has_lit = has_lit;
        beat_lit     = lit;
        in_if.valid      <= 1'b1;
        in_if.char_code  <= b.char_code;
        in_if.last_char  <= b.last_char;
        in_if.empty_text <= b.empty_text;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
    endtask

    task automatic sender_pause(input int n);
        repeat (n) begin
            @(negedge i_clk);
            in_if.valid <= 1'b0;
        end
    endtask

    task automatic wait_results_drained();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_tail_limit(input logic [PRE_LEN_W-1:0] v);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [CHAR_W-1:0] digit_char();
        return CH_0 + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [CHAR_W-1:0] tail_char();
        case ($urandom_range(0, 3))
            0: return digit_char();
            1: return CH_UA + 8'($urandom_range(0, 25));
            2: return CH_LA + 8'($urandom_range(0, 25));
            default: return CH_DOT;
        endcase
    endfunction

    task automatic push_char(input logic [CHAR_W-1:0] c);
        text_q.insert(text_q.size(), '{c, 1'b0, 1'b0});
    endtask

    task automatic push_piece(input int len);
        logic nines;
        nines = ($urandom_range(0, 7) == 0);
        for (int i = 0; i < len; i++) push_char(nines ? CH_9 : digit_char());
    endtask

    task automatic build_text();
        int kind;
        int pieces;
        int r;
        int tl;
        int total;
        kind = $urandom_range(0, 99);
        text_q.delete();
        if (kind < 85) begin
            pieces = ($urandom_range(0, 9) < 2) ? $urandom_range(0, 5) : 3;
            for (int p = 0; p < pieces; p++) begin
                if (p > 0) push_char(CH_DOT);
                r = $urandom_range(0, 19);
                push_piece(r == 0 ? 0 : r == 1 ? 10 : r == 2 ? $urandom_range(11, 12) :
                           $urandom_range(1, 9));
            end
            if ($urandom_range(0, 5) == 0) push_char(CH_DOT);
            if ($urandom_range(0, 1) == 1) begin
                push_char(CH_DASH);
                r = $urandom_range(0, 7);
                tl = r == 0 ? 0 : r == 1 ? max_tail_len : r == 2 ? max_tail_len + 1 :
                     $urandom_range(1, 12);
                for (int i = 0; i < tl; i++) push_char(tail_char());
                if (tl > 0 && $urandom_range(0, 7) == 0)
                    text_q[text_q.size() - 1 - $urandom_range(0, tl - 1)].char_code =
                        8'($urandom_range(0, 255));
            end
            if (kind >= 70 && text_q.size() > 0)
                text_q[$urandom_range(0, text_q.size() - 1)].char_code =
                    8'($urandom_range(0, 255));
        end else if (kind < 90) begin
            r = $urandom_range(1, 8);
            for (int i = 0; i < r; i++) push_char(8'($urandom_range(0, 255)));
        end else if (kind < 95) begin
            for (int p = 0; p < 3; p++) begin
                if (p > 0) push_char(CH_DOT);
                push_piece($urandom_range(1, 9));
            end
            if ($urandom_range(0, 3) != 0) push_char(CH_DASH);
            total = $urandom_range(60, 70);
            while (text_q.size() < total) push_char(tail_char());
        end
        if (text_q.size() > 0 && $urandom_range(0, 7) == 0)
            text_q.insert($urandom_range(0, text_q.size() - 1),
                          '{8'($urandom_range(0, 255)), 1'b0, 1'b1});
        if (text_q.size() == 0 || $urandom_range(0, 7) == 0)
            text_q.insert(text_q.size(), '{8'($urandom_range(0, 255)), 1'b1, 1'b1});
        else
            text_q[text_q.size() - 1].last_char = 1'b1;
    endtask

    initial begin
        int                   phase_items;
        logic [PRE_LEN_W-1:0] limit;
        t_char_beat           b;
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.char_code  = '0;
        in_if.last_char  = 1'b0;
        in_if.empty_text = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.data      = '0;
        hold_req         = 1'b0;
        no_idle          = 1'b0;
        beat_has_lit     = 1'b0;
        beat_lit         = NO_LIT;
        max_tail_len     = PRE_LEN_RESET;
        clear_text_state();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < ROWS; i++) begin
            if ($urandom_range(0, 9) == 0) sender_pause($urandom_range(1, 19));
            send_beat(directed_table[i].beat, directed_table[i].has_lit,
                      directed_table[i].lit);
        end
        wait_results_drained();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: limit = 6'd63;
                1: limit = 6'd1;
                2: limit = 6'd0;
                3: limit = PRE_LEN_RESET;
                default: limit = 6'($urandom_range(0, 63));
            endcase
            write_tail_limit(limit);
            if (p == 1) hold_req = 1'b1;
            if (p == PHASES - 1) no_idle = 1'b1;
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                build_text();
                foreach (text_q[i]) begin
                    b = text_q[i];
                    if (!no_idle && $urandom_range(0, 9) == 0)
                        sender_pause($urandom_range(1, 19));
                    send_beat(b, 1'b0, NO_LIT);
                    if (!(b.empty_text && !b.last_char)) phase_items++;
                end
            end
            wait_results_drained();
        end

        repeat (4) @(posedge i_clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
